// ===== design/apss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apss_pkg
// Shared types and constants for the ATA PIO LBA28 sector sequencer.
// ----------------------------------------------------------------------------
package apss_pkg;

	localparam int WORDS_PER_SECTOR = 256;
	localparam int CNT_W            = $clog2(WORDS_PER_SECTOR + 1);

	// action queue depth, power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_HOST  = 2'd2;
	localparam logic [1:0] REQ_BUS   = 2'd3;

	localparam logic [7:0] ST_BSY = 8'h80;
	localparam logic [7:0] ST_RDY = 8'h40;
	localparam logic [7:0] ST_DF  = 8'h20;
	localparam logic [7:0] ST_ERR = 8'h01;

	localparam logic [2:0] PORT_DATA  = 3'd0;
	localparam logic [2:0] PORT_COUNT = 3'd2;
	localparam logic [2:0] PORT_LBA0  = 3'd3;
	localparam logic [2:0] PORT_LBA1  = 3'd4;
	localparam logic [2:0] PORT_LBA2  = 3'd5;
	localparam logic [2:0] PORT_DRIVE = 3'd6;
	localparam logic [2:0] PORT_CMD   = 3'd7;

	localparam logic [7:0] DRIVE_LBA   = 8'hE0;
	localparam logic [7:0] CMD_READ    = 8'h20;
	localparam logic [7:0] CMD_WRITE   = 8'h30;
	localparam logic [7:0] CMD_FLUSH   = 8'hE7;
	localparam logic [7:0] SECTOR_ONE  = 8'h01;

	// what the back end has to emit for one accepted request
	typedef enum logic [3:0] {
		ACT_NONE    = 4'd0,
		ACT_POLL    = 4'd1,
		ACT_CMD     = 4'd2,
		ACT_DONE    = 4'd3,
		ACT_ERR     = 4'd4,
		ACT_RD0     = 4'd5,
		ACT_RDWORD  = 4'd6,
		ACT_RDLAST  = 4'd7,
		ACT_WRWORD  = 4'd8,
		ACT_WRLAST  = 4'd9
	} act_code_t;

	typedef struct packed {
		act_code_t   code;
		logic        wr;
		logic [27:0] lba;
		logic [15:0] data;
	} act_t;

	typedef struct packed {
		logic        bus_valid;
		logic        bus_write;
		logic [2:0]  bus_port;
		logic [15:0] bus_wdata;
		logic        host_valid;
		logic [15:0] host_rdata;
		logic        done_res;
		logic        error;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

// ===== design/apss_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apss_front
// Protocol tracker: follows the transfer phase and turns each accepted
// request into at most one action for the back end.
// ----------------------------------------------------------------------------
module apss_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [1:0]        req_type,
	input  wire logic [27:0]       lba,
	input  wire logic [15:0]       host_word,
	input  wire logic [15:0]       bus_rdata,
	output logic                   act_push,
	output apss_pkg::act_t         act
);

	typedef enum logic [6:0] {
		PH_IDLE        = 7'b0000001,
		PH_WAIT_CMD    = 7'b0000010,
		PH_WAIT_XFER   = 7'b0000100,
		PH_READ_STATUS = 7'b0001000,
		PH_READ_DATA   = 7'b0010000,
		PH_WRITE_DATA  = 7'b0100000,
		PH_WAIT_FLUSH  = 7'b1000000
	} phase_t;

	phase_t                      phase_q, phase_d;
	logic                        wr_q, wr_d;
	logic                        ws_q, ws_d;
	logic [27:0]                 lba_q, lba_d;
	logic [apss_pkg::CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
	logic [7:0]                  st;
	logic                        cnt_end;

	assign st      = bus_rdata[7:0];
	assign cnt_inc = cnt_q + 1'b1;
	assign cnt_end = cnt_inc >= apss_pkg::CNT_W'(apss_pkg::WORDS_PER_SECTOR);

	always_comb begin
		phase_d   = phase_q;
		wr_d      = wr_q;
		ws_d      = ws_q;
		lba_d     = lba_q;
		cnt_d     = cnt_q;
		act.code  = apss_pkg::ACT_NONE;
		act.wr    = wr_q;
		act.lba   = lba_q;
		act.data  = 16'h0000;
		unique case (phase_q)
			PH_IDLE: begin
				if (req_type == apss_pkg::REQ_READ || req_type == apss_pkg::REQ_WRITE) begin
					wr_d     = req_type[0];
					lba_d    = lba;
					phase_d  = PH_WAIT_CMD;
					ws_d     = 1'b0;
					act.code = apss_pkg::ACT_POLL;
				end
			end
			PH_WAIT_CMD, PH_WAIT_XFER, PH_WAIT_FLUSH: begin
				if (req_type == apss_pkg::REQ_BUS) begin
					if (!ws_q) begin
						if ((st & apss_pkg::ST_BSY) == 8'h00) ws_d = 1'b1;
						act.code = apss_pkg::ACT_POLL;
					end else if ((st & apss_pkg::ST_RDY) == 8'h00) begin
						act.code = apss_pkg::ACT_POLL;
					end else begin
						// drive ready: what follows depends on which wait it was
						priority case (1'b1)
							phase_q == PH_WAIT_CMD: begin
								act.code = apss_pkg::ACT_CMD;
								phase_d  = PH_WAIT_XFER;
								ws_d     = 1'b0;
							end
							phase_q == PH_WAIT_XFER: begin
								cnt_d = '0;
								if (wr_q) begin
									phase_d = PH_WRITE_DATA;
								end else begin
									phase_d  = PH_READ_STATUS;
									act.code = apss_pkg::ACT_POLL;
								end
							end
							default: begin
								act.code = apss_pkg::ACT_DONE;
								phase_d  = PH_IDLE;
							end
						endcase
					end
				end
			end
			PH_READ_STATUS: begin
				if (req_type == apss_pkg::REQ_BUS) begin
					if ((st & (apss_pkg::ST_ERR | apss_pkg::ST_DF)) != 8'h00) begin
						act.code = apss_pkg::ACT_ERR;
						phase_d  = PH_IDLE;
					end else begin
						cnt_d    = '0;
						phase_d  = PH_READ_DATA;
						act.code = apss_pkg::ACT_RD0;
					end
				end
			end
			PH_READ_DATA: begin
				if (req_type == apss_pkg::REQ_BUS) begin
					cnt_d    = cnt_inc;
					act.data = bus_rdata;
					if (cnt_end) begin
						act.code = apss_pkg::ACT_RDLAST;
						phase_d  = PH_IDLE;
					end else begin
						act.code = apss_pkg::ACT_RDWORD;
					end
				end
			end
			PH_WRITE_DATA: begin
				if (req_type == apss_pkg::REQ_HOST) begin
					cnt_d    = cnt_inc;
					act.data = host_word;
					if (cnt_end) begin
						act.code = apss_pkg::ACT_WRLAST;
						phase_d  = PH_WAIT_FLUSH;
						ws_d     = 1'b0;
					end else begin
						act.code = apss_pkg::ACT_WRWORD;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	assign act_push = take && (act.code != apss_pkg::ACT_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wr_q    <= 1'b0;
			ws_q    <= 1'b0;
			lba_q   <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			wr_q    <= wr_d;
			ws_q    <= ws_d;
			lba_q   <= lba_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire

// ===== design/apss_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apss_queue
// Short action queue between the protocol tracker and the result generator.
// ----------------------------------------------------------------------------
module apss_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire apss_pkg::act_t    wr_act,
	output logic                   q_full,
	output logic                   q_empty,
	input  wire logic              rd_en,
	output apss_pkg::act_t         rd_act
);

	apss_pkg::act_t                mem_q [apss_pkg::QDEPTH];
	logic [apss_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
	logic [apss_pkg::QPTR_W:0]     cnt_q;

	assign q_full  = cnt_q == (apss_pkg::QPTR_W+1)'(apss_pkg::QDEPTH);
	assign q_empty = cnt_q == '0;
	assign rd_act  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wptr_q] <= wr_act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) wptr_q <= wptr_q + 1'b1;
			if (rd_en) rptr_q <= rptr_q + 1'b1;
			unique case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/apss_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apss_back
// Result generator: expands each queued action into its results, one per
// cycle while the output is empty or being popped, into a single output register.
// ----------------------------------------------------------------------------
module apss_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire apss_pkg::act_t    head,
	output logic                   q_pop,
	input  wire logic              pop,
	output logic                   empty,
	output apss_pkg::res_t         res
);

	logic [2:0]        step_q;
	logic [2:0]        last_step;
	logic              step_last;
	logic              advance;
	logic              out_valid_q;
	apss_pkg::res_t    res_q;
	apss_pkg::res_t    gen;

	always_comb begin
		unique case (head.code)
			apss_pkg::ACT_CMD:    last_step = 3'd6;
			apss_pkg::ACT_WRLAST: last_step = 3'd2;
			default:              last_step = 3'd0;
		endcase
	end

	assign step_last = step_q == last_step;
	assign advance   = !q_empty && (!out_valid_q || pop);
	assign q_pop     = advance && step_last;

	always_comb begin
		gen            = '0;
		gen.last       = step_last;
		unique case (head.code)
			apss_pkg::ACT_CMD: begin
				gen.bus_valid = 1'b1;
				gen.bus_write = 1'b1;
				unique case (step_q)
					3'd0: begin
						gen.bus_port  = apss_pkg::PORT_DRIVE;
						gen.bus_wdata = {8'h00, apss_pkg::DRIVE_LBA | {4'h0, head.lba[27:24]}};
					end
					3'd1: begin
						gen.bus_port  = apss_pkg::PORT_COUNT;
						gen.bus_wdata = {8'h00, apss_pkg::SECTOR_ONE};
					end
					3'd2: begin
						gen.bus_port  = apss_pkg::PORT_LBA0;
						gen.bus_wdata = {8'h00, head.lba[7:0]};
					end
					3'd3: begin
						gen.bus_port  = apss_pkg::PORT_LBA1;
						gen.bus_wdata = {8'h00, head.lba[15:8]};
					end
					3'd4: begin
						gen.bus_port  = apss_pkg::PORT_LBA2;
						gen.bus_wdata = {8'h00, head.lba[23:16]};
					end
					3'd5: begin
						gen.bus_port  = apss_pkg::PORT_CMD;
						gen.bus_wdata = {8'h00, head.wr ? apss_pkg::CMD_WRITE
						                                : apss_pkg::CMD_READ};
					end
					default: begin
						// closing status poll
						gen.bus_write = 1'b0;
						gen.bus_port  = apss_pkg::PORT_CMD;
					end
				endcase
			end
			apss_pkg::ACT_WRLAST: begin
				gen.bus_valid = 1'b1;
				unique case (step_q)
					3'd0: begin
						gen.bus_write = 1'b1;
						gen.bus_port  = apss_pkg::PORT_DATA;
						gen.bus_wdata = head.data;
					end
					3'd1: begin
						gen.bus_write = 1'b1;
						gen.bus_port  = apss_pkg::PORT_CMD;
						gen.bus_wdata = {8'h00, apss_pkg::CMD_FLUSH};
					end
					default: begin
						gen.bus_port  = apss_pkg::PORT_CMD;
					end
				endcase
			end
			apss_pkg::ACT_POLL: begin
				gen.bus_valid = 1'b1;
				gen.bus_port  = apss_pkg::PORT_CMD;
			end
			apss_pkg::ACT_DONE: begin
				gen.done_res = 1'b1;
			end
			apss_pkg::ACT_ERR: begin
				gen.done_res = 1'b1;
				gen.error    = 1'b1;
			end
			apss_pkg::ACT_RD0: begin
				gen.bus_valid = 1'b1;
				gen.bus_port  = apss_pkg::PORT_DATA;
			end
			apss_pkg::ACT_RDWORD: begin
				gen.bus_valid  = 1'b1;
				gen.bus_port   = apss_pkg::PORT_DATA;
				gen.host_valid = 1'b1;
				gen.host_rdata = head.data;
			end
			apss_pkg::ACT_RDLAST: begin
				gen.host_valid = 1'b1;
				gen.host_rdata = head.data;
				gen.done_res   = 1'b1;
			end
			apss_pkg::ACT_WRWORD: begin
				gen.bus_valid = 1'b1;
				gen.bus_write = 1'b1;
				gen.bus_port  = apss_pkg::PORT_DATA;
				gen.bus_wdata = head.data;
			end
			default: begin
				gen = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= gen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				step_q      <= step_last ? 3'd0 : step_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty = !out_valid_q;
	assign res   = res_q;

endmodule
`default_nettype wire

// ===== design/ata_pio_sector_sequencer_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ata_pio_sector_sequencer_unit
// Host-side ATA PIO sequencer for single-sector LBA28 read and write.
// ----------------------------------------------------------------------------
// Input side is a queue: a request is taken at a clock edge with push high
// and full low. Requests are commands, host data words or bus read returns;
// a request that does not fit the current phase is dropped without a result.
// Result side is a queue too: the oldest result sits on the ports while empty
// is low and leaves at an edge with pop high.
// The tracker takes one request per cycle while full is low and queues at
// most one action for it; the generator expands each action into one to
// seven results, one per cycle while the output is empty or being popped.
// The first result of a request passes the action queue and then the output
// register; a command set-up gives seven results, the last write word with
// its flush three, everything else one. full rises when the four-entry action
// queue is full, so a stalled receiver backs up into it and then into push.
// Reset clears the phase, the queues and the output valid flag; the block is
// idle and ready for a command straight after.
// ----------------------------------------------------------------------------
module ata_pio_sector_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  req_type,
	input  wire logic [27:0] lba,
	input  wire logic [15:0] host_word,
	input  wire logic [15:0] bus_rdata,
	output logic             empty,
	input  wire logic        pop,
	output logic             bus_valid,
	output logic             bus_write,
	output logic [2:0]       bus_port,
	output logic [15:0]      bus_wdata,
	output logic             host_valid,
	output logic [15:0]      host_rdata,
	output logic             done_res,
	output logic             error,
	output logic             last
);

	logic              take;
	logic              act_push;
	logic              q_empty;
	logic              q_pop;
	apss_pkg::act_t    act;
	apss_pkg::act_t    head;
	apss_pkg::res_t    res;

	assign take = push && !full;

	apss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.req_type  (req_type),
		.lba       (lba),
		.host_word (host_word),
		.bus_rdata (bus_rdata),
		.act_push  (act_push),
		.act       (act)
	);

	apss_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (act_push),
		.wr_act  (act),
		.q_full  (full),
		.q_empty (q_empty),
		.rd_en   (q_pop),
		.rd_act  (head)
	);

	apss_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign bus_valid  = res.bus_valid;
	assign bus_write  = res.bus_write;
	assign bus_port   = res.bus_port;
	assign bus_wdata  = res.bus_wdata;
	assign host_valid = res.host_valid;
	assign host_rdata = res.host_rdata;
	assign done_res   = res.done_res;
	assign error      = res.error;
	assign last       = res.last;

endmodule
`default_nettype wire
